>>> hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types for the 3D point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Default coordinate width and number of fraction bits in the result.
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Number of spatial dimensions.
    localparam int DIMS = 3;

    // Control that travels beside every pipeline stage and cell.
    typedef struct packed {
        logic valid;
        logic degen;
    } psd_ctl_t;

endpackage

>>> hdl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Forms the exact squared distance as a ratio num / den over six stages:
// differences, products, dot and cross sums, clamp decision with split
// squares, square assembly, and final selection.
// ----------------------------------------------------------------------------
module psd_front
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] a_pt [DIMS],
    input  logic signed [COORD_BITS-1:0] b_pt [DIMS],
    input  logic signed [COORD_BITS-1:0] c_pt [DIMS],
    output psd_ctl_t                     ctl,
    output logic [4*(COORD_BITS+1)+1:0]  num,
    output logic [2*(COORD_BITS+1)+1:0]  den
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int SQW = PW + 2;
    localparam int MW  = PW;
    localparam int LO  = MW / 2;
    localparam int HI  = MW - LO;
    localparam int NW  = 2 * MW + 2;

    psd_ctl_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;

    logic signed [DW-1:0]  d_reg [DIMS];
    logic signed [DW-1:0]  v_reg [DIMS];
    logic signed [DW-1:0]  w_reg [DIMS];

    logic signed [PW-1:0]  dd_p_reg [DIMS];
    logic signed [PW-1:0]  vv_p_reg [DIMS];
    logic signed [PW-1:0]  ww_p_reg [DIMS];
    logic signed [PW-1:0]  t_p_reg  [DIMS];
    logic signed [PW-1:0]  xa_p_reg [DIMS];
    logic signed [PW-1:0]  xb_p_reg [DIMS];

    logic [SQW-1:0]        dd_reg, vv_reg, ww_reg;
    logic signed [SQW-1:0] t_reg;
    logic [MW-1:0]         xm_reg [DIMS];

    logic [SQW-1:0]        simple_reg, den4_reg;
    logic                  mid4_reg;
    logic [2*HI-1:0]       hh_reg [DIMS];
    logic [HI+LO-1:0]      hl_reg [DIMS];
    logic [2*LO-1:0]       ll_reg [DIMS];

    logic [SQW-1:0]        simple5_reg, den5_reg;
    logic                  mid5_reg;
    logic [2*MW-1:0]       sq_reg [DIMS];

    logic [NW-1:0]         num_reg;
    logic [SQW-1:0]        den_reg;

    logic                  degen4;
    logic                  tpos;
    logic                  tge;
    logic signed [PW:0]    xdiff [DIMS];

    // Clamp decision on the projection parameter.
    assign degen4 = (dd_reg == '0);
    assign tpos   = !t_reg[SQW-1] && (t_reg != '0);
    assign tge    = ($unsigned(t_reg) >= dd_reg);

    // Cross product components, signed.
    always_comb
    begin
        for (int k = 0; k < DIMS; k++)
        begin
            xdiff[k] = (PW+1)'(xa_p_reg[k]) - (PW+1)'(xb_p_reg[k]);
        end
    end

    // Stage valid bits and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= '{valid: in_valid, degen: 1'b0};
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= '{valid: s3_reg.valid, degen: degen4};
            s5_reg <= s4_reg;
            s6_reg <= s5_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIMS; i++)
            begin
                d_reg[i] <= DW'(b_pt[i]) - DW'(a_pt[i]);
                v_reg[i] <= DW'(c_pt[i]) - DW'(a_pt[i]);
                w_reg[i] <= DW'(c_pt[i]) - DW'(b_pt[i]);

                dd_p_reg[i] <= d_reg[i] * d_reg[i];
                vv_p_reg[i] <= v_reg[i] * v_reg[i];
                ww_p_reg[i] <= w_reg[i] * w_reg[i];
                t_p_reg[i]  <= v_reg[i] * d_reg[i];
                xa_p_reg[i] <= v_reg[(i + 1) % DIMS] * d_reg[(i + 2) % DIMS];
                xb_p_reg[i] <= v_reg[(i + 2) % DIMS] * d_reg[(i + 1) % DIMS];

                xm_reg[i] <= xdiff[i][PW] ? MW'(-xdiff[i]) : MW'(xdiff[i]);

                hh_reg[i] <= xm_reg[i][MW-1:LO] * xm_reg[i][MW-1:LO];
                hl_reg[i] <= xm_reg[i][MW-1:LO] * xm_reg[i][LO-1:0];
                ll_reg[i] <= xm_reg[i][LO-1:0] * xm_reg[i][LO-1:0];

                sq_reg[i] <= ((2*MW)'(hh_reg[i]) << (2 * LO))
                           + ((2*MW)'(hl_reg[i]) << (LO + 1))
                           + (2*MW)'(ll_reg[i]);
            end

            // Dot products as sums of the squared and mixed terms.
            dd_reg <= SQW'($unsigned(dd_p_reg[0])) + SQW'($unsigned(dd_p_reg[1]))
                    + SQW'($unsigned(dd_p_reg[2]));
            vv_reg <= SQW'($unsigned(vv_p_reg[0])) + SQW'($unsigned(vv_p_reg[1]))
                    + SQW'($unsigned(vv_p_reg[2]));
            ww_reg <= SQW'($unsigned(ww_p_reg[0])) + SQW'($unsigned(ww_p_reg[1]))
                    + SQW'($unsigned(ww_p_reg[2]));
            t_reg  <= SQW'(t_p_reg[0]) + SQW'(t_p_reg[1]) + SQW'(t_p_reg[2]);

            // Clamp to the nearer end, or keep the interior case.
            if (degen4 || !tpos)
            begin
                simple_reg <= vv_reg;
                mid4_reg   <= 1'b0;
            end
            else if (tge)
            begin
                simple_reg <= ww_reg;
                mid4_reg   <= 1'b0;
            end
            else
            begin
                simple_reg <= vv_reg;
                mid4_reg   <= 1'b1;
            end
            den4_reg <= dd_reg;

            simple5_reg <= simple_reg;
            den5_reg    <= den4_reg;
            mid5_reg    <= mid4_reg;

            // Interior: |v x d|^2 / dd; end cases: squared length over one.
            if (mid5_reg)
            begin
                num_reg <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]);
                den_reg <= den5_reg;
            end
            else
            begin
                num_reg <= NW'(simple5_reg);
                den_reg <= SQW'(1);
            end
        end
    end

    assign ctl = s6_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

>>> hdl/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step: brings down one dividend bit and produces
// one quotient bit, shifted into the same register.
// ----------------------------------------------------------------------------
module psd_div_cell
    import psd_pkg::*;
#(
    parameter int DEN_W = 36,
    parameter int Q_W   = 68
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  psd_ctl_t         ctl_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [Q_W-1:0]   dq_in,
    output psd_ctl_t         ctl_out,
    output logic [DEN_W-1:0] den_out,
    output logic [DEN_W-1:0] rem_out,
    output logic [Q_W-1:0]   dq_out
);

    psd_ctl_t         ctl_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [Q_W-1:0]   dq_reg;
    logic [DEN_W:0]   rem2;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Trial subtraction of the divisor.
    assign rem2 = {rem_in, dq_in[Q_W-1]};
    assign diff = rem2 - {1'b0, den_in};
    assign ge   = (rem2 >= {1'b0, den_in});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rem_reg <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            dq_reg  <= {dq_in[Q_W-2:0], ge};
        end
    end

    assign ctl_out = ctl_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;

endmodule

>>> hdl/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square root step: brings down two radicand bits and
// produces one root bit.
// ----------------------------------------------------------------------------
module psd_sqrt_cell
    import psd_pkg::*;
#(
    parameter int X_W = 68,
    parameter int R_W = 34
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  psd_ctl_t       ctl_in,
    input  logic [X_W-1:0] x_in,
    input  logic [R_W+1:0] rem_in,
    input  logic [R_W-1:0] root_in,
    output psd_ctl_t       ctl_out,
    output logic [X_W-1:0] x_out,
    output logic [R_W+1:0] rem_out,
    output logic [R_W-1:0] root_out
);

    psd_ctl_t       ctl_reg;
    logic [X_W-1:0] x_reg;
    logic [R_W+1:0] rem_reg;
    logic [R_W-1:0] root_reg;
    logic [R_W+3:0] rem2;
    logic [R_W+3:0] trial;
    logic [R_W+3:0] diff;
    logic           ge;

    // Trial subtraction of 4*root + 1.
    assign rem2  = {rem_in, x_in[X_W-1:X_W-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = rem2 - trial;
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= {x_in[X_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[R_W+1:0] : rem2[R_W+1:0];
            root_reg <= {root_in[R_W-2:0], ge};
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

>>> hdl/point_segment_distance_3d_top.sv
// ----------------------------------------------------------------------------
// point_segment_distance_3d_top
// Distance from point C to segment AB in 3D, unsigned fixed point,
// rounded down.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  input   | in_valid / in_ready        | ax ay az bx by_coord bz cx cy cz
//  output  | out_valid / out_ready      | distance degenerate
//
//  One transaction is taken per cycle while no result waits; each result
//  passes through the front end, then the chain of divider cells and the
//  chain of square root cells.
//  The whole pipeline advances together and holds while a result waits.
//  Reset clears the valid and degen control bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_top
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       ax,
    input  logic signed [COORD_BITS-1:0]       ay,
    input  logic signed [COORD_BITS-1:0]       az,
    input  logic signed [COORD_BITS-1:0]       bx,
    input  logic signed [COORD_BITS-1:0]       by_coord,
    input  logic signed [COORD_BITS-1:0]       bz,
    input  logic signed [COORD_BITS-1:0]       cx,
    input  logic signed [COORD_BITS-1:0]       cy,
    input  logic signed [COORD_BITS-1:0]       cz,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [COORD_BITS+FRAC_BITS:0]      distance,
    output logic                               degenerate
);

    localparam int DW    = COORD_BITS + 1;
    localparam int SQW   = 2 * DW + 2;
    localparam int NW    = 4 * DW + 2;
    localparam int QW    = SQW + 2 * FRAC_BITS;
    localparam int RW    = QW / 2;
    localparam int DISTW = COORD_BITS + FRAC_BITS + 1;

    logic                         en;
    logic signed [COORD_BITS-1:0] a_pt [DIMS];
    logic signed [COORD_BITS-1:0] b_pt [DIMS];
    logic signed [COORD_BITS-1:0] c_pt [DIMS];
    psd_ctl_t                     f_ctl;
    logic [NW-1:0]                f_num;
    logic [SQW-1:0]               f_den;

    psd_ctl_t                     dv_ctl [QW+1];
    logic [SQW-1:0]               dv_den [QW+1];
    logic [SQW-1:0]               dv_rem [QW+1];
    logic [QW-1:0]                dv_dq  [QW+1];

    psd_ctl_t                     sq_ctl  [RW+1];
    logic [QW-1:0]                sq_x    [RW+1];
    logic [RW+1:0]                sq_rem  [RW+1];
    logic [RW-1:0]                sq_root [RW+1];

    // The whole pipe moves unless a result is waiting.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign a_pt[0] = ax;
    assign a_pt[1] = ay;
    assign a_pt[2] = az;
    assign b_pt[0] = bx;
    assign b_pt[1] = by_coord;
    assign b_pt[2] = bz;
    assign c_pt[0] = cx;
    assign c_pt[1] = cy;
    assign c_pt[2] = cz;

    // Squared distance as an exact ratio.
    psd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .a_pt     (a_pt),
        .b_pt     (b_pt),
        .c_pt     (c_pt),
        .ctl      (f_ctl),
        .num      (f_num),
        .den      (f_den)
    );

    // Divider chain: quotient of num * 2^(2*FRAC_BITS) by den.
    assign dv_ctl[0] = f_ctl;
    assign dv_den[0] = f_den;
    assign dv_rem[0] = SQW'(f_num[NW-1:SQW]);
    assign dv_dq[0]  = {f_num[SQW-1:0], {(2*FRAC_BITS){1'b0}}};

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        psd_div_cell #(
            .DEN_W (SQW),
            .Q_W   (QW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (dv_ctl[i]),
            .den_in  (dv_den[i]),
            .rem_in  (dv_rem[i]),
            .dq_in   (dv_dq[i]),
            .ctl_out (dv_ctl[i+1]),
            .den_out (dv_den[i+1]),
            .rem_out (dv_rem[i+1]),
            .dq_out  (dv_dq[i+1])
        );
    end

    // Square root chain over the quotient.
    assign sq_ctl[0]  = dv_ctl[QW];
    assign sq_x[0]    = dv_dq[QW];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        psd_sqrt_cell #(
            .X_W (QW),
            .R_W (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (sq_ctl[j]),
            .x_in     (sq_x[j]),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .ctl_out  (sq_ctl[j+1]),
            .x_out    (sq_x[j+1]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1])
        );
    end

    // The last square root cell is the output register.
    assign out_valid  = sq_ctl[RW].valid;
    assign degenerate = sq_ctl[RW].degen;
    assign distance   = sq_root[RW][DISTW-1:0];

    // A degenerate segment never reaches the divider with a real divisor.
    a_degen_den: assert property (@(posedge clk) disable iff (!rst_n)
        f_ctl.valid && f_ctl.degen |-> f_den == SQW'(1))
        else $error("degenerate transaction with divisor other than one");

    // The division remainder always ends below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_ctl[QW].valid |-> dv_rem[QW] < dv_den[QW])
        else $error("division remainder not below divisor");

    // The square root remainder never exceeds twice the root.
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_ctl[RW].valid |-> sq_rem[RW] <= {1'b0, sq_root[RW], 1'b0})
        else $error("square root remainder too large");

endmodule
